>>> hdl/mmc3m_pkg.sv
// ----------------------------------------------------------------------------
// mmc3m_pkg: shared types and constants of the bank mapper
// Command codes, register decode codes, transaction structs and field widths.
// ----------------------------------------------------------------------------
package mmc3m_pkg;

	localparam int BANK_W     = 6;
	localparam int STEP_CNT_W = $clog2(BANK_W);
	localparam int COUNT_W    = 7;
	localparam int OFFSET_W   = 19;

	localparam logic [COUNT_W-1:0] BANK_COUNT_MIN   = 7'd2;
	localparam logic [COUNT_W-1:0] BANK_COUNT_MAX   = 7'd64;
	localparam logic [COUNT_W-1:0] BANK_COUNT_RESET = 7'd16;

	typedef enum logic [1:0] {
		CMD_PRG_WRITE = 2'd0,
		CMD_PRG_READ  = 2'd1,
		CMD_PAT_READ  = 2'd2,
		CMD_TICK      = 2'd3
	} cmd_t;

	// address bits 14:13 of a program write
	typedef enum logic [1:0] {
		REG_BANK   = 2'd0,
		REG_MIRROR = 2'd1,
		REG_IRQ    = 2'd2,
		REG_ENABLE = 2'd3
	} reg_grp_t;

	// configuration register indexes
	localparam logic CFG_BANK_COUNT = 1'b0;
	localparam logic CFG_PAT_RAM    = 1'b1;

	typedef struct packed {
		cmd_t        command;
		logic [15:0] address;
		logic [7:0]  value;
	} in_item_t;

	typedef struct packed {
		logic [OFFSET_W-1:0] rom_offset;
		logic                irq_pulse;
		logic                mirror_update;
		logic                mirror_horizontal;
	} out_item_t;

endpackage

>>> hdl/mmc3m_mod.sv
// ----------------------------------------------------------------------------
// mmc3m_mod: iterative bank number reduction
// Restoring remainder unit, one dividend bit per cycle, shared compare/subtract.
// ----------------------------------------------------------------------------
module mmc3m_mod import mmc3m_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [BANK_W-1:0]  dividend,
	input  logic [COUNT_W-1:0] divisor,
	output logic               done,
	output logic [BANK_W-1:0]  remainder
);

	logic                  busy_q;
	logic [STEP_CNT_W-1:0] cnt_q;
	logic [BANK_W-1:0]     rem_q;
	logic [BANK_W-1:0]     dvd_q;
	logic [COUNT_W-1:0]    trial;
	logic [COUNT_W-1:0]    diff;
	logic                  fits;

	assign trial = {rem_q, dvd_q[BANK_W-1]};
	assign fits  = (trial >= divisor);
	assign diff  = trial - divisor;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= STEP_CNT_W'(BANK_W - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
		end else if (busy_q) begin
			// remainder stays below the divisor, so it fits the bank width
			rem_q <= fits ? diff[BANK_W-1:0] : trial[BANK_W-1:0];
			dvd_q <= {dvd_q[BANK_W-2:0], 1'b0};
		end
	end

	assign done      = busy_q && (cnt_q == '0);
	assign remainder = rem_q;

endmodule

>>> hdl/bank_switch_mapper_with_scanline_irq_top.sv
// ----------------------------------------------------------------------------
// bank_switch_mapper_with_scanline_irq_top: cartridge bank mapper with IRQ
// A program bank write (registers 6 and 7) passes ST_DIV, where the 6-step
// remainder unit reduces the bank number, before ST_EXEC like all commands.
// Throughput: one transaction at a time, the next may start once busy is low.
// done is a one-cycle strobe that the receiver cannot stall.
// Reset: asynchronous, clears all mapper state, pattern slot 1 maps bank 1.
// ----------------------------------------------------------------------------
module bank_switch_mapper_with_scanline_irq_top import mmc3m_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  in_item_t           item,
	output logic               done,
	output out_item_t          result,
	input  logic               wr_en,
	input  logic               wr_index,
	input  logic [COUNT_W-1:0] wr_data
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_EXEC = 3'b100
	} state_t;

	state_t             state_q;
	in_item_t           item_q;
	logic [COUNT_W-1:0] bank_count_q;
	logic               pat_ram_q;
	logic [7:0]         select_q;
	logic               irq_en_q;
	logic [7:0]         irq_reload_q;
	logic [7:0]         irq_count_q;
	logic [BANK_W-1:0]  prg_bank_q [3];
	logic [7:0]         pat_bank_q [8];
	logic               done_q;
	out_item_t          result_q;

	logic               accept;
	logic               needs_mod;
	logic               mod_done;
	logic [BANK_W-1:0]  mod_rem;
	logic [COUNT_W-1:0] count_eff;
	logic [BANK_W-1:0]  last_bank;
	logic [BANK_W-1:0]  second_last;
	reg_grp_t           grp;
	logic               odd;
	logic               inv;
	logic [1:0]         slot;
	logic [2:0]         pslot;
	logic [7:0]         dec_count;
	out_item_t          result_next;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);

	// bank data for register 6 or 7 needs the bank number reduced modulo the count
	assign needs_mod = (item.command == CMD_PRG_WRITE) && (item.address[14:13] == REG_BANK)
		&& item.address[0] && (select_q[2:1] == 2'b11);

	always_comb begin
		if (bank_count_q < BANK_COUNT_MIN) begin
			count_eff = BANK_COUNT_MIN;
		end else if (bank_count_q > BANK_COUNT_MAX) begin
			count_eff = BANK_COUNT_MAX;
		end else begin
			count_eff = bank_count_q;
		end
	end

	assign last_bank   = BANK_W'(count_eff - 7'd1);
	assign second_last = BANK_W'(count_eff - 7'd2);

	mmc3m_mod u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (accept && needs_mod),
		.dividend  (item.value[BANK_W-1:0]),
		.divisor   (count_eff),
		.done      (mod_done),
		.remainder (mod_rem)
	);

	assign grp       = reg_grp_t'(item_q.address[14:13]);
	assign odd       = item_q.address[0];
	assign inv       = select_q[7];
	assign slot      = item_q.address[14:13];
	assign pslot     = item_q.address[12:10];
	assign dec_count = irq_count_q - 8'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= needs_mod ? ST_DIV : ST_EXEC;
					end
				end
				ST_DIV: begin
					if (mod_done) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_count_q <= BANK_COUNT_RESET;
			pat_ram_q    <= 1'b0;
		end else if (wr_en) begin
			case (wr_index)
				CFG_BANK_COUNT: bank_count_q <= wr_data;
				CFG_PAT_RAM:    pat_ram_q    <= wr_data[0];
				default:        ;
			endcase
		end
	end

	// mapper state, updated in the execute cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			select_q     <= '0;
			irq_en_q     <= 1'b0;
			irq_reload_q <= '0;
			irq_count_q  <= '0;
			for (int i = 0; i < 3; i++) begin
				prg_bank_q[i] <= '0;
			end
			for (int i = 0; i < 8; i++) begin
				pat_bank_q[i] <= (i == 1) ? 8'd1 : 8'd0;
			end
		end else if (state_q == ST_EXEC) begin
			case (item_q.command)
				CMD_PRG_WRITE: begin
					case (grp)
						REG_BANK: begin
							if (!odd) begin
								select_q <= item_q.value;
							end else begin
								case (select_q[2:0])
									3'd0: begin
										pat_bank_q[inv ? 3'd4 : 3'd0] <= {item_q.value[7:1], 1'b0};
										pat_bank_q[inv ? 3'd5 : 3'd1] <= {item_q.value[7:1], 1'b1};
									end
									3'd1: begin
										pat_bank_q[inv ? 3'd6 : 3'd2] <= {item_q.value[7:1], 1'b0};
										pat_bank_q[inv ? 3'd7 : 3'd3] <= {item_q.value[7:1], 1'b1};
									end
									3'd2: pat_bank_q[inv ? 3'd0 : 3'd4] <= item_q.value;
									3'd3: pat_bank_q[inv ? 3'd1 : 3'd5] <= item_q.value;
									3'd4: pat_bank_q[inv ? 3'd2 : 3'd6] <= item_q.value;
									3'd5: pat_bank_q[inv ? 3'd3 : 3'd7] <= item_q.value;
									3'd6: begin
										if (select_q[6]) begin
											prg_bank_q[0] <= second_last;
											prg_bank_q[2] <= mod_rem;
										end else begin
											prg_bank_q[0] <= mod_rem;
											prg_bank_q[2] <= second_last;
										end
									end
									default: prg_bank_q[1] <= mod_rem;
								endcase
							end
						end
						REG_IRQ: begin
							if (odd) begin
								irq_count_q <= '0;
							end else begin
								irq_reload_q <= item_q.value;
							end
						end
						REG_ENABLE: irq_en_q <= odd;
						default: ;
					endcase
				end
				CMD_TICK: begin
					irq_count_q <= (irq_count_q == '0) ? irq_reload_q : dec_count;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (state_q == ST_EXEC);
		end
	end

	always_comb begin
		result_next = '0;
		case (item_q.command)
			CMD_PRG_WRITE: begin
				if ((grp == REG_MIRROR) && !odd) begin
					result_next.mirror_update     = 1'b1;
					result_next.mirror_horizontal = item_q.value[0];
				end
			end
			CMD_PRG_READ: begin
				if (slot == 2'd3) begin
					result_next.rom_offset = {last_bank, item_q.address[12:0]};
				end else begin
					result_next.rom_offset = {prg_bank_q[slot], item_q.address[12:0]};
				end
			end
			CMD_PAT_READ: begin
				if (pat_ram_q) begin
					result_next.rom_offset = OFFSET_W'(item_q.address[12:0]);
				end else begin
					result_next.rom_offset = OFFSET_W'({pat_bank_q[pslot], item_q.address[9:0]});
				end
			end
			default: begin
				result_next.irq_pulse = (irq_count_q != '0) && (dec_count == '0) && irq_en_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EXEC) begin
			result_q <= result_next;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule
